FILE: rtl/dib_pkg.sv
// Shared types and constants for the deleted-identifier bitmap block.
package dib_pkg;

    localparam int ID_W       = 16;
    localparam int NEXT_W     = 17;
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int BIT_IDX_W  = 3;
    localparam int BYTE_IDX_W = ID_W - BIT_IDX_W;
    localparam int CMP_W      = BYTE_IDX_W + 1;
    localparam int MAX_BYTES  = 1 << BYTE_IDX_W;

    typedef enum logic [OP_W-1:0] {
        OP_MARK = 2'd0,
        OP_TEST = 2'd1,
        OP_FIND = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK_WR,
        ST_TEST,
        ST_FIND
    } state_t;

endpackage

FILE: rtl/dib_ram.sv
// Generic single-port RAM with registered read data.
module dib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/deleted_id_bitmap_core.sv
// Top level of the deleted-identifier bitmap: sequencer, extent and result registers.
//
//  channel   | signals                         | handshake
//  ----------+---------------------------------+---------------------------------
//  command   | start, opcode, doc_id -> busy   | beat taken when start && !busy
//  result    | done, is_marked, next_id        | one-cycle strobe, no back-pressure
//
// A mark is a read-modify-write on the single RAM port; a test reads the byte and
// registers the bit, and a test or mark that needs no RAM access answers from idle.
// A find whose start lies beyond the extent also answers from idle; else it walks
// the bitmap bytes in order until a clear bit or the end of the extent, and the
// single RAM read port sets the pace. After reset the block sweeps the bitmap RAM
// to zero, one byte a cycle, over min(ceil(MAX_DOCS/8), 8192) bytes with busy high.
// Results cannot be stalled; done pulses for one cycle per command.
module deleted_id_bitmap_core #(
    parameter int MAX_DOCS = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dib_pkg::OP_W-1:0]    opcode,
    input  logic [dib_pkg::ID_W-1:0]    doc_id,
    output logic                        done,
    output logic                        is_marked,
    output logic [dib_pkg::NEXT_W-1:0]  next_id
);

    import dib_pkg::*;

    // Only identifiers below 2^16 can arrive, so cap the store there.
    localparam int STORE_BYTES = (MAX_DOCS + BYTE_W - 1) / BYTE_W;
    localparam int MEM_DEPTH   = (STORE_BYTES < MAX_BYTES) ? STORE_BYTES : MAX_BYTES;
    localparam int AW          = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int UB_W        = $clog2(MEM_DEPTH + 1);
    localparam bit ALL_IDS_OK  = (MAX_DOCS >= (1 << ID_W));

    state_t                 state_reg, state_next;
    logic [AW-1:0]          byte_reg, byte_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [UB_W-1:0]        used_bytes_reg, used_bytes_next;
    logic                   done_reg, done_next;
    logic                   is_marked_reg, is_marked_next;
    logic [NEXT_W-1:0]      next_id_reg, next_id_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [BYTE_W-1:0]      ram_wdata;
    logic [BYTE_W-1:0]      ram_rdata;

    // Decode of the incoming command.
    logic                   accept;
    op_t                    op_in;
    logic [BYTE_IDX_W-1:0]  id_byte;
    logic [BIT_IDX_W-1:0]   id_bit;
    logic                   id_in_range;
    logic                   byte_in_extent;
    logic                   id_in_extent;
    logic [NEXT_W-1:0]      limit_id;

    // Scan of the byte just read.
    logic [BYTE_W-1:0]      clear_cand;
    logic                   clear_found;
    logic [BIT_IDX_W-1:0]   clear_pos;
    logic                   scan_last;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign op_in    = op_t'(opcode);
    assign id_byte  = doc_id[ID_W-1:BIT_IDX_W];
    assign id_bit   = doc_id[BIT_IDX_W-1:0];
    assign limit_id = NEXT_W'({used_bytes_reg, {BIT_IDX_W{1'b0}}});

    assign id_in_range    = ALL_IDS_OK || ({1'b0, doc_id} < NEXT_W'(MAX_DOCS));
    assign byte_in_extent = CMP_W'(id_byte) < CMP_W'(used_bytes_reg);
    assign id_in_extent   = NEXT_W'(doc_id) < limit_id;

    // Clear bits at or above the starting bit position; pick the lowest.
    assign clear_cand = ~ram_rdata & (8'hFF << bit_reg);
    assign clear_found = |clear_cand;
    assign scan_last = (CMP_W'(byte_reg) + CMP_W'(1)) >= CMP_W'(used_bytes_reg);

    always_comb
    begin
        clear_pos = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (clear_cand[i])
            begin
                clear_pos = BIT_IDX_W'(i);
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (byte_reg == AW'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_in)
                        OP_MARK:
                        begin
                            if (id_in_range)
                            begin
                                state_next = ST_MARK_WR;
                            end
                        end
                        OP_TEST:
                        begin
                            if (byte_in_extent)
                            begin
                                state_next = ST_TEST;
                            end
                        end
                        OP_FIND:
                        begin
                            if (id_in_extent)
                            begin
                                state_next = ST_FIND;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MARK_WR: state_next = ST_IDLE;
            ST_TEST:    state_next = ST_IDLE;
            ST_FIND:
            begin
                if (clear_found || scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM control and results.
    always_comb
    begin
        byte_next       = byte_reg;
        bit_next        = bit_reg;
        used_bytes_next = used_bytes_reg;
        done_next       = 1'b0;
        is_marked_next  = is_marked_reg;
        next_id_next    = next_id_reg;
        ram_we          = 1'b0;
        ram_addr        = byte_reg;
        ram_wdata       = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the store to zero.
                ram_we    = 1'b1;
                byte_next = (byte_reg == AW'(MEM_DEPTH - 1)) ? '0 : byte_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    byte_next      = AW'(id_byte);
                    bit_next       = id_bit;
                    ram_addr       = AW'(id_byte);
                    is_marked_next = 1'b0;
                    next_id_next   = '0;
                    case (op_in)
                        OP_MARK:
                        begin
                            // Grow the extent now; the bit goes in next cycle.
                            if (id_in_range)
                            begin
                                if (!byte_in_extent)
                                begin
                                    used_bytes_next = UB_W'(CMP_W'(id_byte) + CMP_W'(1));
                                end
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        OP_TEST:
                        begin
                            done_next = !byte_in_extent;
                        end
                        OP_FIND:
                        begin
                            if (!id_in_extent)
                            begin
                                next_id_next = NEXT_W'(doc_id);
                                done_next    = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_MARK_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | (BYTE_W'(1) << bit_reg);
                done_next = 1'b1;
            end
            ST_TEST:
            begin
                is_marked_next = ram_rdata[bit_reg];
                done_next      = 1'b1;
            end
            ST_FIND:
            begin
                if (clear_found)
                begin
                    next_id_next = NEXT_W'({byte_reg, clear_pos});
                    done_next    = 1'b1;
                end
                else if (scan_last)
                begin
                    next_id_next = limit_id;
                    done_next    = 1'b1;
                end
                else
                begin
                    // Advance to the next byte; scan it from bit zero.
                    byte_next = byte_reg + AW'(1);
                    bit_next  = '0;
                    ram_addr  = byte_reg + AW'(1);
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            byte_reg       <= '0;
            used_bytes_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            byte_reg       <= byte_next;
            used_bytes_reg <= used_bytes_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg       <= bit_next;
        is_marked_reg <= is_marked_next;
        next_id_reg   <= next_id_next;
    end

    dib_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_DEPTH)
    ) u_bits (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign done      = done_reg;
    assign is_marked = is_marked_reg;
    assign next_id   = next_id_reg;

    // The extent never runs past the store.
    a_extent_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(used_bytes_reg) <= CMP_W'(MEM_DEPTH))
        else $error("extent exceeds store depth");

    // A scan only ever reads bytes inside the extent.
    a_scan_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIND) |-> (CMP_W'(byte_reg) < CMP_W'(used_bytes_reg)))
        else $error("scan byte outside extent");

    // The store is written only by the clearing sweep or a mark.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_MARK_WR))
        else $error("unexpected store write");

    // No result appears during or right after the clearing sweep.
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !done_reg)
        else $error("result during clearing sweep");

    // A mark or test that reaches the RAM always ends in a result.
    a_finish_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK_WR || state_reg == ST_TEST) |=> done_reg)
        else $error("command finished without result");

endmodule
